// ----- sv/egd_pkg.sv -----
`timescale 1ns / 1ps
package egd_pkg;

  localparam int FLOOR_W = 4;
  localparam int CAR_W   = 3;
  localparam int EV_W    = 3;
  localparam int SCORE_W = 18;
  localparam int MAX_RES = 16;
  localparam int NRES_W  = 5;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_REQ   = 2'd1,
    KIND_MAINT = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [EV_W-1:0] {
    EV_DEPART = 3'd0,
    EV_ARRIVE = 3'd1,
    EV_ASSIGN = 3'd2,
    EV_NOCAR  = 3'd3,
    EV_FULL   = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2,
    DIR_RSVD = 2'd3
  } dir_t;

  localparam logic CFG_PENALTY = 1'b0;
  localparam logic CFG_WEIGHT  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_T_CAR,
    S_T_AFTERUP,
    S_T_DECIDE,
    S_T_TAKE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_REM_RD,
    S_REM_WR,
    S_M_NEXT,
    S_M_REM,
    S_D_SCORE,
    S_D_DO,
    S_EMIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [EV_W-1:0]    ev;
    logic [CAR_W-1:0]   car;
    logic [FLOOR_W-1:0] from_fl;
    logic [FLOOR_W-1:0] to_fl;
  } result_t;

  typedef struct packed {
    logic    push;
    logic    flush;
    result_t data;
  } rb_cmd_t;

endpackage

// ----- sv/egd_if.sv -----
`timescale 1ns / 1ps
interface egd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] floor;
  logic [2:0] car;
  logic       maintenance_on;

  modport source(output valid, kind, floor, car, maintenance_on, input ready);
  modport sink(input valid, kind, floor, car, maintenance_on, output ready);
endinterface

interface egd_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [2:0] car_index;
  logic [3:0] from_floor;
  logic [3:0] to_floor;
  logic       last;

  modport source(output valid, event_res, car_index, from_floor, to_floor, last,
                 input ready);
  modport sink(input valid, event_res, car_index, from_floor, to_floor, last,
               output ready);
endinterface

// ----- sv/egd_store_ram.sv -----
`timescale 1ns / 1ps
module egd_store_ram #(
  parameter int DEPTH = 48,
  parameter int AW    = 6,
  parameter int DW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/egd_result_buf.sv -----
`timescale 1ns / 1ps
module egd_result_buf (
  input  logic              clk,
  input  logic              rst,
  input  egd_pkg::rb_cmd_t  cmd,
  output logic              rdy,
  egd_res_if.source         res
);
  import egd_pkg::*;

  // one result held back until we know whether it is the last one
  logic    pend_v;
  result_t pend;

  assign rdy = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v    <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        pend   <= cmd.data;
        pend_v <= 1'b1;
      end else if (cmd.flush) begin
        pend_v <= 1'b0;
      end
      if ((cmd.push || cmd.flush) && pend_v) begin
        res.valid      <= 1'b1;
        res.event_res  <= pend.ev;
        res.car_index  <= pend.car;
        res.from_floor <= pend.from_fl;
        res.to_floor   <= pend.to_fl;
        res.last       <= cmd.flush;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/elevator_group_dispatcher_core.sv -----
`timescale 1ns / 1ps
// Group dispatcher for up to eight elevator cars. One transaction is taken at a time:
// a tick steps every car, a floor request is scored against all cars and stored in the
// winner's up or down store, and entering maintenance drains that car's stores and
// redispatches each entry. Floor stores live in one synchronous RAM (one entry per
// car, direction and slot); car state and store counts are flops. A tick scans an idle
// car's stores with a read then a compare per entry through the single RAM read port;
// a drain costs one scan plus one dispatch per stored entry. Results are pushed
// through a one-deep hold stage so the final result carries last; results past the
// sixteenth are dropped while their dispatch still happens. Output stalls hold the
// sequencer. Config writes take effect at once and must only be made while idle.
module elevator_group_dispatcher_core #(
  parameter int NUM_CARS    = 3,
  parameter int NUM_FLOORS  = 16,
  parameter int STORE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  egd_req_if.sink     req,
  egd_res_if.source   res,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import egd_pkg::*;

  localparam int CIW   = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
  localparam int CPW   = $clog2(NUM_CARS + 1);
  localparam int SW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW    = $clog2(STORE_DEPTH + 1);
  localparam int DEPTH = NUM_CARS * 2 * STORE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [15:0] penalty;
  logic [7:0]  weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      penalty <= 16'd1000;
      weight  <= 8'd10;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PENALTY) penalty <= cfg_data;
      else                          weight  <= cfg_data[7:0];
    end
  end

  // per-car state
  logic [FLOOR_W-1:0] car_floor [NUM_CARS];
  dir_t               car_dir   [NUM_CARS];
  logic               car_mov   [NUM_CARS];
  logic [FLOOR_W-1:0] car_tgt   [NUM_CARS];
  logic [FLOOR_W-1:0] car_cd    [NUM_CARS];
  logic               car_mnt   [NUM_CARS];
  logic [CW-1:0]      cnt       [NUM_CARS][2];

  // sequencer
  state_t state, state_next;
  state_t ret, sret, rret, dret;
  logic [CPW-1:0]     cp, dc;
  logic [CIW-1:0]     icar, scar, bestc;
  logic               sdir;
  logic [SW-1:0]      si, ridx;
  logic [FLOOR_W-1:0] sval [2];
  logic [SW-1:0]      sidx [2];
  logic               fu, fd, nd;
  logic               found;
  logic [SCORE_W-1:0] bests;
  logic [FLOOR_W-1:0] dfl, nxt;
  logic [NRES_W-1:0]  n;
  result_t            eres;

  rb_cmd_t rb_cmd;
  logic    rb_rdy;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [3:0]    mem_wdata, mem_rdata;

  function automatic logic [AW-1:0] st_addr(input logic [CIW-1:0] c, input logic d,
                                             input logic [SW-1:0] s);
    st_addr = AW'((int'(c) * 2 + int'(d)) * STORE_DEPTH + int'(s));
  endfunction

  function automatic logic [FLOOR_W-1:0] floor_gap(input logic [FLOOR_W-1:0] a,
                                                   input logic [FLOOR_W-1:0] b);
    floor_gap = (a > b) ? a - b : b - a;
  endfunction

  // current-car views
  logic [CIW-1:0]     cc, dcc;
  logic [FLOOR_W-1:0] t_cf, t_cdn;
  logic               t_arrive, t_skip;
  logic [CW-1:0]      t_u, t_d;
  logic               t_fu, t_fd, t_nu, t_nd;
  logic [FLOOR_W-1:0] k_cf;
  logic               k_td;
  logic [CW-1:0]      s_cnt;
  logic               s_better, s_done;
  logic               d_avail, d_ok;
  logic [FLOOR_W-1:0] d_cf;
  logic [CW:0]        d_load;
  logic [SCORE_W-1:0] d_score;
  logic [FLOOR_W-1:0] b_cf;
  logic               b_dir;
  logic [CW-1:0]      b_cnt;
  logic               b_full, b_same;
  logic [FLOOR_W-1:0] in_fl;
  logic               in_car_ok;

  assign cc    = cp[CIW-1:0];
  assign dcc   = dc[CIW-1:0];
  assign t_cf  = car_floor[cc];
  assign t_cdn = (car_cd[cc] != '0) ? car_cd[cc] - 1'b1 : car_cd[cc];
  assign t_arrive = car_mov[cc] && (t_cdn == '0);
  assign t_u   = cnt[cc][0];
  assign t_d   = cnt[cc][1];
  assign t_skip = car_mnt[cc] || (t_u == '0 && t_d == '0);
  assign t_fu  = (car_dir[cc] == DIR_UP) && (t_u != '0);
  assign t_fd  = !t_fu && (car_dir[cc] == DIR_DOWN) && (t_d != '0);
  assign t_nu  = (t_u != '0) && !t_fd;
  assign t_nd  = (t_d != '0) && !t_fu;

  // keep the current direction if its store has work; else strict nearness picks down, otherwise up
  assign k_cf = car_floor[scar];
  assign k_td = fd || (!fu && (cnt[scar][1] != '0) &&
                ((cnt[scar][0] == '0) ||
                 (floor_gap(sval[1], k_cf) < floor_gap(sval[0], k_cf))));

  assign s_cnt    = cnt[scar][sdir];
  assign s_better = sdir ? (mem_rdata > sval[sdir]) : (mem_rdata < sval[sdir]);
  assign s_done   = (CW'(si) + 1'b1) >= s_cnt;

  assign d_avail = !car_mov[dcc] && !car_mnt[dcc];
  assign d_cf    = car_floor[dcc];
  assign d_ok    = (dfl > d_cf && car_dir[dcc] != DIR_DOWN) ||
                   (dfl < d_cf && car_dir[dcc] != DIR_UP) || (car_dir[dcc] == DIR_IDLE);
  assign d_load  = {1'b0, cnt[dcc][0]} + {1'b0, cnt[dcc][1]};
  assign d_score = (d_ok ? SCORE_W'(0) : SCORE_W'(penalty)) + SCORE_W'(floor_gap(d_cf, dfl))
                   + SCORE_W'(d_load) * SCORE_W'(weight);

  assign b_cf   = car_floor[bestc];
  assign b_same = (dfl == b_cf);
  assign b_dir  = (dfl < b_cf);
  assign b_cnt  = cnt[bestc][b_dir];
  assign b_full = (int'(b_cnt) >= STORE_DEPTH);

  assign in_fl     = (int'(req.floor) >= NUM_FLOORS) ? FLOOR_W'(NUM_FLOORS - 1) : req.floor;
  assign in_car_ok = (int'(req.car) < NUM_CARS);

  assign req.ready = (state == S_IDLE);

  // next state, RAM and result-buffer controls
  always_comb begin
    state_next    = state;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    rb_cmd        = '0;
    rb_cmd.data   = eres;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          priority case (kind_t'(req.kind))
            KIND_TICK: state_next = S_T_CAR;
            KIND_REQ:  state_next = S_D_SCORE;
            KIND_MAINT: state_next = (in_car_ok && req.maintenance_on) ? S_M_NEXT : S_FIN;
            default:   state_next = S_FIN;
          endcase
        end
      end
      S_T_CAR: begin
        if (int'(cp) >= NUM_CARS) state_next = S_FIN;
        else if (car_mov[cc]) state_next = t_arrive ? S_EMIT : S_T_CAR;
        else if (t_skip) state_next = S_T_CAR;
        else state_next = S_SCAN_RD;
      end
      S_T_AFTERUP: state_next = nd ? S_SCAN_RD : S_T_DECIDE;
      S_T_DECIDE:  state_next = S_REM_RD;
      S_T_TAKE:    state_next = (nxt != k_cf) ? S_EMIT : S_T_CAR;
      S_SCAN_RD: begin
        mem_raddr  = st_addr(scar, sdir, si);
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: state_next = s_done ? sret : S_SCAN_RD;
      S_REM_RD: begin
        mem_raddr  = st_addr(scar, sdir, SW'(s_cnt - 1'b1));
        state_next = S_REM_WR;
      end
      S_REM_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = st_addr(scar, sdir, ridx);
        mem_wdata  = mem_rdata;
        state_next = rret;
      end
      S_M_NEXT: begin
        if (cnt[icar][0] != '0 || cnt[icar][1] != '0) state_next = S_SCAN_RD;
        else state_next = S_FIN;
      end
      S_M_REM:   state_next = S_REM_RD;
      S_D_SCORE: state_next = (int'(dc) + 1 >= NUM_CARS) ? S_D_DO : S_D_SCORE;
      S_D_DO: begin
        if (found && !b_same && !b_full) begin
          mem_we    = 1'b1;
          mem_waddr = st_addr(bestc, b_dir, SW'(b_cnt));
          mem_wdata = dfl;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (int'(n) >= MAX_RES) state_next = ret;
        else if (rb_rdy) begin
          rb_cmd.push = 1'b1;
          state_next  = ret;
        end
      end
      S_FIN: begin
        if (rb_rdy) begin
          rb_cmd.flush = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // car state and counts (control, cleared on reset)
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CARS; c++) begin
        car_floor[c] <= '0;
        car_dir[c]   <= DIR_IDLE;
        car_mov[c]   <= 1'b0;
        car_tgt[c]   <= '0;
        car_cd[c]    <= '0;
        car_mnt[c]   <= 1'b0;
        cnt[c][0]    <= '0;
        cnt[c][1]    <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid && kind_t'(req.kind) == KIND_MAINT && in_car_ok) begin
            car_mnt[req.car[CIW-1:0]] <= req.maintenance_on;
          end
        end
        S_T_CAR: begin
          if (int'(cp) < NUM_CARS && car_mov[cc]) begin
            car_cd[cc] <= t_cdn;
            if (t_arrive) begin
              car_floor[cc] <= car_tgt[cc];
              car_mov[cc]   <= 1'b0;
            end
          end
        end
        S_T_DECIDE: car_dir[scar] <= k_td ? DIR_DOWN : DIR_UP;
        S_T_TAKE: begin
          if (nxt != k_cf) begin
            car_tgt[scar] <= nxt;
            car_mov[scar] <= 1'b1;
            car_cd[scar]  <= floor_gap(nxt, k_cf);
          end
        end
        S_REM_WR: cnt[scar][sdir] <= s_cnt - 1'b1;
        S_D_DO: begin
          if (found && !b_same && !b_full) cnt[bestc][b_dir] <= b_cnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          n     <= '0;
          cp    <= '0;
          dc    <= '0;
          found <= 1'b0;
          dfl   <= in_fl;
          dret  <= S_FIN;
          icar  <= req.car[CIW-1:0];
        end
        S_T_CAR: begin
          if (int'(cp) < NUM_CARS) begin
            if (car_mov[cc] || t_skip) begin
              cp <= cp + 1'b1;
              if (t_arrive) begin
                eres <= '{EV_ARRIVE, CAR_W'(cc), t_cf, car_tgt[cc]};
                ret  <= S_T_CAR;
              end
            end else begin
              fu   <= t_fu;
              fd   <= t_fd;
              nd   <= t_nd;
              scar <= cc;
              si   <= '0;
              sdir <= !t_nu;
              sret <= t_nu ? S_T_AFTERUP : S_T_DECIDE;
            end
          end
        end
        S_T_AFTERUP: begin
          sdir <= 1'b1;
          si   <= '0;
          sret <= S_T_DECIDE;
        end
        S_T_DECIDE: begin
          nxt  <= sval[k_td];
          ridx <= sidx[k_td];
          sdir <= k_td;
          rret <= S_T_TAKE;
        end
        S_T_TAKE: begin
          cp <= cp + 1'b1;
          if (nxt != k_cf) begin
            eres <= '{EV_DEPART, CAR_W'(scar), k_cf, nxt};
            ret  <= S_T_CAR;
          end
        end
        S_SCAN_CMP: begin
          if (si == '0 || s_better) begin
            sval[sdir] <= mem_rdata;
            sidx[sdir] <= si;
          end
          si <= si + 1'b1;
        end
        S_M_NEXT: begin
          scar <= icar;
          si   <= '0;
          sdir <= (cnt[icar][0] == '0);
          sret <= S_M_REM;
        end
        S_M_REM: begin
          dfl   <= sval[sdir];
          ridx  <= sidx[sdir];
          rret  <= S_D_SCORE;
          dret  <= S_M_NEXT;
          dc    <= '0;
          found <= 1'b0;
        end
        S_D_SCORE: begin
          if (d_avail && (!found || d_score < bests)) begin
            found <= 1'b1;
            bestc <= dcc;
            bests <= d_score;
          end
          dc <= dc + 1'b1;
        end
        S_D_DO: begin
          ret <= dret;
          if (!found)      eres <= '{EV_NOCAR, '0, '0, dfl};
          else if (b_same || !b_full)
                           eres <= '{EV_ASSIGN, CAR_W'(bestc), b_cf, dfl};
          else             eres <= '{EV_FULL, CAR_W'(bestc), b_cf, dfl};
        end
        S_EMIT: begin
          if (rb_cmd.push) n <= n + 1'b1;
        end
        default: ;
      endcase
    end
  end

  egd_store_ram #(.DEPTH(DEPTH), .AW(AW), .DW(FLOOR_W)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  egd_result_buf u_rb (
    .clk (clk),
    .rst (rst),
    .cmd (rb_cmd),
    .rdy (rb_rdy),
    .res (res)
  );

  // never more than the result cap goes out per transaction
  a_cap: assert property (@(posedge clk) disable iff (rst)
    rb_cmd.push |-> (int'(n) < MAX_RES))
    else $error("result cap exceeded");

  // never remove from an empty store
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_REM_WR) |-> (s_cnt != '0))
    else $error("remove from empty store");

  // an accepted transaction always leaves idle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != S_IDLE))
    else $error("transaction accepted without work");

  // RAM write never races the scan read of the same cycle
  a_port: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_REM_WR || state == S_D_DO))
    else $error("unexpected store write");

endmodule
